/* design/cpaf_pkg.sv */
// Shared types, widths and helper functions for the cell positive area fraction pipeline
package cpaf_pkg;

    // Corner width, scaled value width (x4), difference width, product width
    localparam int IW  = 32;
    localparam int VW  = IW + 2;
    localparam int DW  = VW + 1;
    localparam int PW  = 2 * DW;
    // Output fraction bits and output width (one extra bit holds the whole cell)
    localparam int OFB = 16;
    localparam int OW  = OFB + 1;
    // Split of a magnitude into low and high halves for the partial products
    localparam int LW  = (DW + 1) / 2;
    localparam int HW  = DW - LW;
    // Pipeline depth: front end, partial products, sum, compare, divide steps, output
    localparam int NST = OFB + 7;
    localparam logic [OW-1:0] ONE = OW'(1) << OFB;

    typedef enum logic [1:0] {
        K_ONE,
        K_ZERO,
        K_RATIO,
        K_ERR
    } t_kind;

    // Selected operands of one triangle
    typedef struct packed {
        t_kind           kind;
        logic            pos;
        logic [DW-1:0]   ms;
        logic [DW-1:0]   m1;
        logic [DW-1:0]   m2;
    } t_sel;

    // Partial products of one triangle
    typedef struct packed {
        t_kind              kind;
        logic               pos;
        logic [2*LW-1:0]    ss_ll;
        logic [LW+HW-1:0]   ss_lh;
        logic [2*HW-1:0]    ss_hh;
        logic [2*LW-1:0]    dd_ll;
        logic [LW+HW-1:0]   dd_lh;
        logic [LW+HW-1:0]   dd_hl;
        logic [2*HW-1:0]    dd_hh;
    } t_part;

    // Divider state of one triangle
    typedef struct packed {
        t_kind          kind;
        logic           pos;
        logic           sat;
        logic [PW:0]    num;
        logic [PW-1:0]  den;
        logic [OFB-1:0] q;
    } t_lane;

    // Absolute value of a signed difference
    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
        logic [DW-1:0] r;
        r = x[DW-1] ? DW'(-x) : DW'(x);
        return r;
    endfunction

    // True when n/d lies in [0,1] with d nonzero
    function automatic logic crossing_ok(input logic signed [DW-1:0] n,
                                         input logic signed [DW-1:0] d);
        logic r;
        if (d > 0) begin
            r = (n >= 0) && (n <= d);
        end else if (d < 0) begin
            r = (n <= 0) && (n >= d);
        end else begin
            r = 1'b0;
        end
        return r;
    endfunction

    // One restoring division step
    function automatic t_lane div_step(input t_lane x);
        t_lane       y;
        logic [PW:0] sh;
        y  = x;
        sh = {x.num[PW-1:0], 1'b0};
        if (!x.sat) begin
            if (sh >= {1'b0, x.den}) begin
                y.num = sh - {1'b0, x.den};
                y.q   = {x.q[OFB-2:0], 1'b1};
            end else begin
                y.num = sh;
                y.q   = {x.q[OFB-2:0], 1'b0};
            end
        end
        return y;
    endfunction

endpackage

/* design/cell_positive_area_fraction_top.sv */
// Pipelined positive area fraction of one square cell from its four corner values
// Stages from input transfer to output valid: 5 front stages, 1 compare stage, one stage
// per output fraction bit of the restoring divider, 1 output stage.
// Throughput: one cell per cycle; each stage holds only while the stage after it is
// full and stalled, so bubbles close up under back pressure.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data needs no reset.
module cell_positive_area_fraction_top
    import cpaf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [IW-1:0] i_corner_a,
    input  logic signed [IW-1:0] i_corner_b,
    input  logic signed [IW-1:0] i_corner_c,
    input  logic signed [IW-1:0] i_corner_d,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OW-1:0]        o_positive_fraction,
    output logic                 o_logic_error
);

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_adv;

    logic signed [VW-1:0] r_e1;
    logic signed [VW-1:0] r_v1 [4];
    logic signed [VW-1:0] r_e2;
    logic signed [VW-1:0] r_v2 [4];
    logic signed [DW-1:0] r_dpq [4];
    logic signed [DW-1:0] r_drq [4];
    logic signed [DW-1:0] r_dpr [4];
    t_sel                 r_sel [4];
    t_sel                 n_sel [4];
    t_part                r_part [4];
    t_lane                r_dv [OFB+1][4];
    t_lane                n_nd [4];
    logic [OW-1:0]        r_frac;
    logic                 r_err;
    logic [OW-1:0]        n_frac;
    logic                 n_err;

    // Advance a stage when it is empty or the stage after it advances
    assign w_adv[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end
    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];

    // Move valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: scale corners by four, centre is their sum
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_e1    <= VW'(i_corner_a) + VW'(i_corner_b) + VW'(i_corner_c)
                       + VW'(i_corner_d);
            r_v1[0] <= {i_corner_a, 2'b00};
            r_v1[1] <= {i_corner_b, 2'b00};
            r_v1[2] <= {i_corner_c, 2'b00};
            r_v1[3] <= {i_corner_d, 2'b00};
        end
    end

    // Stage 1: side differences of each triangle (centre, v[i], v[i+1])
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_e2 <= r_e1;
            for (int l = 0; l < 4; l++) begin
                r_v2[l]  <= r_v1[l];
                r_dpq[l] <= DW'(r_e1) - DW'(r_v1[l]);
                r_drq[l] <= DW'(r_v1[(l+1)%4]) - DW'(r_v1[l]);
                r_dpr[l] <= DW'(r_e1) - DW'(r_v1[(l+1)%4]);
            end
        end
    end

    // Stage 2: classify each triangle and pick the ratio operands
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            logic signed [VW-1:0] p, q, r;
            logic                 pq, qr, pr;
            logic [DW-1:0]        apq, arq, apr;
            p   = r_e2;
            q   = r_v2[l];
            r   = r_v2[(l+1)%4];
            pq  = crossing_ok(DW'(p), r_dpq[l]);
            qr  = crossing_ok(DW'(r), r_drq[l]);
            pr  = crossing_ok(DW'(p), r_dpr[l]);
            apq = mag(r_dpq[l]);
            arq = mag(r_drq[l]);
            apr = mag(r_dpr[l]);
            n_sel[l].kind = K_RATIO;
            n_sel[l].pos  = p > 0;
            n_sel[l].ms   = mag(DW'(p));
            n_sel[l].m1   = apq;
            n_sel[l].m2   = apr;
            if (p > 0 && q > 0 && r > 0) begin
                n_sel[l].kind = K_ONE;
            end else if (p < 0 && q < 0 && r < 0) begin
                n_sel[l].kind = K_ZERO;
            end else if (!qr && pq && pr) begin
                n_sel[l].kind = K_RATIO;
            end else if (!pr && pq && qr) begin
                n_sel[l].pos = q > 0;
                n_sel[l].ms  = mag(DW'(q));
                n_sel[l].m2  = arq;
            end else if (!pq && pr && qr) begin
                n_sel[l].pos = r > 0;
                n_sel[l].ms  = mag(DW'(r));
                n_sel[l].m1  = apr;
                n_sel[l].m2  = arq;
            end else begin
                n_sel[l].kind = K_ERR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_sel <= n_sel;
        end
    end

    // Stage 3: partial products of s*s and m1*m2
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int l = 0; l < 4; l++) begin
                r_part[l].kind  <= r_sel[l].kind;
                r_part[l].pos   <= r_sel[l].pos;
                r_part[l].ss_ll <= r_sel[l].ms[LW-1:0] * r_sel[l].ms[LW-1:0];
                r_part[l].ss_lh <= r_sel[l].ms[LW-1:0] * r_sel[l].ms[DW-1:LW];
                r_part[l].ss_hh <= r_sel[l].ms[DW-1:LW] * r_sel[l].ms[DW-1:LW];
                r_part[l].dd_ll <= r_sel[l].m1[LW-1:0] * r_sel[l].m2[LW-1:0];
                r_part[l].dd_lh <= r_sel[l].m1[LW-1:0] * r_sel[l].m2[DW-1:LW];
                r_part[l].dd_hl <= r_sel[l].m1[DW-1:LW] * r_sel[l].m2[LW-1:0];
                r_part[l].dd_hh <= r_sel[l].m1[DW-1:LW] * r_sel[l].m2[DW-1:LW];
            end
        end
    end

    // Stage 4: sum partials into numerator and denominator
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_nd[l].kind = r_part[l].kind;
            n_nd[l].pos  = r_part[l].pos;
            n_nd[l].sat  = 1'b0;
            n_nd[l].q    = '0;
            n_nd[l].num  = (PW+1)'((PW'(r_part[l].ss_hh) << (2*LW))
                           + (PW'(r_part[l].ss_lh) << (LW+1)) + PW'(r_part[l].ss_ll));
            n_nd[l].den  = (PW'(r_part[l].dd_hh) << (2*LW))
                           + (PW'(r_part[l].dd_lh) << LW) + (PW'(r_part[l].dd_hl) << LW)
                           + PW'(r_part[l].dd_ll);
        end
    end

    logic [PW:0]   r_num4 [4];
    logic [PW-1:0] r_den4 [4];
    t_kind         r_kind4 [4];
    logic          r_pos4 [4];

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int l = 0; l < 4; l++) begin
                r_num4[l]  <= n_nd[l].num;
                r_den4[l]  <= n_nd[l].den;
                r_kind4[l] <= n_nd[l].kind;
                r_pos4[l]  <= n_nd[l].pos;
            end
        end
    end

    // Stage 5: saturate when the ratio reaches one
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int l = 0; l < 4; l++) begin
                r_dv[0][l].kind <= r_kind4[l];
                r_dv[0][l].pos  <= r_pos4[l];
                r_dv[0][l].sat  <= r_num4[l] >= {1'b0, r_den4[l]};
                r_dv[0][l].num  <= r_num4[l];
                r_dv[0][l].den  <= r_den4[l];
                r_dv[0][l].q    <= '0;
            end
        end
    end

    // Stages 6 on: one quotient bit per stage
    for (genvar g = 1; g <= OFB; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_adv[5+g]) begin
                for (int l = 0; l < 4; l++) begin
                    r_dv[g][l] <= div_step(r_dv[g-1][l]);
                end
            end
        end
    end

    // Last stage: triangle fractions, mean rounded half up, error flag
    always_comb begin
        logic [OW+1:0] sum;
        logic [OW-1:0] ratio;
        logic [OW-1:0] f;
        sum   = '0;
        n_err = 1'b0;
        for (int l = 0; l < 4; l++) begin
            ratio = r_dv[OFB][l].sat ? ONE : {1'b0, r_dv[OFB][l].q};
            case (r_dv[OFB][l].kind)
                K_ONE:   f = ONE;
                K_ZERO:  f = '0;
                K_RATIO: f = r_dv[OFB][l].pos ? ratio : ONE - ratio;
                default: begin
                    f     = '0;
                    n_err = 1'b1;
                end
            endcase
            sum = sum + (OW+2)'(f);
        end
        sum    = sum + (OW+2)'(2);
        n_frac = n_err ? '0 : sum[OW+1:2];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_frac <= n_frac;
            r_err  <= n_err;
        end
    end

    assign o_positive_fraction = r_frac;
    assign o_logic_error       = r_err;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_logic_error |-> o_positive_fraction == '0)
        else $error("error result with nonzero fraction");
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_positive_fraction <= ONE)
        else $error("fraction above whole cell");
    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("transfer lost at pipeline entry");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_positive_fraction)
            && $stable(o_logic_error))
        else $error("output stage dropped a stalled result");
`endif

endmodule
